// ----- hw/rtl/lzwd_pkg.sv -----
// ----------------------------------------------------------------------------
// lzwd_pkg: shared types and constants of the LZ window decompressor
// Holds the command word that the parser passes to the copy engine.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // Version bytes that select a token format.
  localparam logic [7:0] VER1_BYTE = 8'h31;
  localparam logic [7:0] VER2_BYTE = 8'h32;

  // Format codes.
  localparam logic [1:0] FMT_RAW = 2'd0;
  localparam logic [1:0] FMT_V1  = 2'd1;
  localparam logic [1:0] FMT_V2  = 2'd2;

  // Widest history address the block supports.
  localparam int unsigned ADDR_W_MAX = 16;

  // Kinds of command word.
  typedef enum logic [1:0] {
    CMD_LIT  = 2'd0,
    CMD_COPY = 2'd1,
    CMD_FLAG = 2'd2
  } cmd_kind_t;

  // One parsed input word, ready for the copy engine.
  typedef struct packed {
    cmd_kind_t              kind;
    logic [7:0]             data;
    logic [7:0]             len;
    logic [ADDR_W_MAX-1:0]  rd_addr;
    logic [ADDR_W_MAX-1:0]  wr_addr;
    logic                   done;
    logic                   bad;
  } cmd_t;

endpackage

// ----- hw/rtl/lzwd_if.sv -----
// ----------------------------------------------------------------------------
// lzwd_if: stream channels of the LZ window decompressor
// Input word channel and packed result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lzwd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface lzwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte0;
  logic [7:0] out_byte1;
  logic [7:0] out_byte2;
  logic [7:0] out_byte3;
  logic [2:0] byte_count;
  logic       run_last;
  logic       stream_done;
  logic       bad_distance;

  modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                  output out_byte3, output byte_count, output run_last,
                  output stream_done, output bad_distance, input ready);
  modport sink (input valid, input out_byte0, input out_byte1, input out_byte2,
                input out_byte3, input byte_count, input run_last,
                input stream_done, input bad_distance, output ready);
endinterface

// ----- hw/rtl/lz_window_decompressor_core.sv -----
// ----------------------------------------------------------------------------
// lz_window_decompressor_core: streaming LZ window decompressor
// Parser front end, two-entry command queue and history copy engine.
// ----------------------------------------------------------------------------
// A literal or raw word goes from the command queue through the engine's idle
// state, which writes history, and the flush state into the result register.
// A match is taken from the queue in the idle state; each copied word then takes
// a history read state and a write state, and each packed result a flush state.
// Throughput: header and token words are taken one per cycle while the queue
// has room; copy length through the history RAM sets the sustained rate.
// Reset clears parser, queue and engine control; the history RAM is not cleared.
module lz_window_decompressor_core #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned OUT_LANES     = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  lzwd_in_if.sink     in_if,
  lzwd_out_if.source  out_if
);

  logic           q_push;
  logic           q_full;
  logic           q_pop;
  logic           q_valid;
  lzwd_pkg::cmd_t q_wdata;
  lzwd_pkg::cmd_t q_head;

  lzwd_front #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_wdata)
  );

  lzwd_cmd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_wdata),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head       (q_head)
  );

  lzwd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .OUT_LANES     (OUT_LANES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule

// ----- hw/rtl/lzwd_ram.sv -----
// ----------------------------------------------------------------------------
// lzwd_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/lzwd_front.sv -----
// ----------------------------------------------------------------------------
// lzwd_front: header and token parser
// Accepts one word per cycle while the command queue has room, tracks the output count and issues commands.
// ----------------------------------------------------------------------------
module lzwd_front #(
  parameter int unsigned HISTORY_DEPTH = 65536
) (
  input  logic           clk,
  input  logic           rst_n,
  lzwd_in_if.sink        in_if,
  input  logic           q_full,
  output logic           q_push,
  output lzwd_pkg::cmd_t q_data
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [16:0] DEPTH_17 = 17'(HISTORY_DEPTH);

  typedef enum logic [9:0] {
    PH_HDR0  = 10'b0000000001,
    PH_VER   = 10'b0000000010,
    PH_SZLO  = 10'b0000000100,
    PH_SZHI  = 10'b0000001000,
    PH_RAW   = 10'b0000010000,
    PH_TOKEN = 10'b0000100000,
    PH_LIT   = 10'b0001000000,
    PH_V1LO  = 10'b0010000000,
    PH_V2HI  = 10'b0100000000,
    PH_V2LO  = 10'b1000000000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [1:0]      mode_r, mode_nxt;
  logic [15:0]     target_r, target_nxt;
  logic [16:0]     bw_r, bw_nxt;
  logic [7:0]      lit_r, lit_nxt;
  logic [7:0]      mlen_r, mlen_nxt;
  logic [7:0]      dhi_r, dhi_nxt;
  logic [AW-1:0]   wptr_r, wptr_nxt;

  logic            accept;
  logic [7:0]      b;
  logic [16:0]     match_dist;
  logic            dist_bad;
  logic [16:0]     avail;
  logic [7:0]      ncopy;
  logic [AW:0]     rd_diff;
  logic [AW:0]     rd_wrap;
  logic [AW-1:0]   rd_addr;
  logic [AW:0]     wp_sum;
  logic [AW:0]     wp_wrap;
  logic            has_cmd;
  logic            done;
  lzwd_pkg::cmd_t  cmd;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign b           = in_if.in_byte;

  // Match geometry: distance, room left before the target size, source address.
  always_comb begin
    match_dist = {1'b0, dhi_r, b} + 17'd1;
    dist_bad   = (match_dist > bw_r) || (match_dist > DEPTH_17);
    avail      = {1'b0, target_r} - bw_r;
    ncopy      = ({9'd0, mlen_r} > avail) ? avail[7:0] : mlen_r;
    rd_diff    = {1'b0, wptr_r} - match_dist[AW:0];
    rd_wrap    = rd_diff + DEPTH_W;
    rd_addr    = rd_diff[AW] ? rd_wrap[AW-1:0] : rd_diff[AW-1:0];
  end

  // Parser step for the word on the input.
  always_comb begin
    phase_nxt  = phase_r;
    mode_nxt   = mode_r;
    target_nxt = target_r;
    bw_nxt     = bw_r;
    lit_nxt    = lit_r;
    mlen_nxt   = mlen_r;
    dhi_nxt    = dhi_r;
    wp_sum     = {1'b0, wptr_r};
    has_cmd    = 1'b0;
    done       = 1'b0;
    cmd        = '0;
    cmd.kind   = lzwd_pkg::CMD_FLAG;
    cmd.data   = b;
    cmd.wr_addr = lzwd_pkg::ADDR_W_MAX'(wptr_r);
    cmd.rd_addr = lzwd_pkg::ADDR_W_MAX'(rd_addr);

    unique case (phase_r)
      PH_VER: begin
        mode_nxt  = (b == lzwd_pkg::VER1_BYTE) ? lzwd_pkg::FMT_V1 :
                    ((b == lzwd_pkg::VER2_BYTE) ? lzwd_pkg::FMT_V2 : lzwd_pkg::FMT_RAW);
        phase_nxt = PH_SZLO;
      end
      PH_SZLO: begin
        target_nxt = {8'd0, b};
        phase_nxt  = PH_SZHI;
      end
      PH_SZHI: begin
        target_nxt = {b, target_r[7:0]};
        bw_nxt     = '0;
        lit_nxt    = '0;
        mlen_nxt   = '0;
        dhi_nxt    = '0;
        wp_sum     = '0;
        phase_nxt  = (mode_r == lzwd_pkg::FMT_RAW) ? PH_RAW : PH_TOKEN;
      end
      PH_RAW, PH_LIT: begin
        if (bw_r < {1'b0, target_r}) begin
          has_cmd  = 1'b1;
          cmd.kind = lzwd_pkg::CMD_LIT;
          bw_nxt   = bw_r + 17'd1;
          wp_sum   = {1'b0, wptr_r} + (AW + 1)'(1);
        end
        if (phase_r == PH_LIT) begin
          lit_nxt = lit_r - 8'd1;
          if (lit_r == 8'd1) begin
            phase_nxt = PH_TOKEN;
          end
        end
      end
      PH_TOKEN: begin
        if (b[7]) begin
          if (mode_r == lzwd_pkg::FMT_V1) begin
            mlen_nxt  = {4'd0, b[6:3]} + 8'd3;
            dhi_nxt   = {5'd0, b[2:0]};
            phase_nxt = PH_V1LO;
          end else begin
            mlen_nxt  = {1'b0, b[6:0]} + 8'd4;
            phase_nxt = PH_V2HI;
          end
        end else begin
          lit_nxt   = {1'b0, b[6:0]} + 8'd1;
          phase_nxt = PH_LIT;
        end
      end
      PH_V2HI: begin
        dhi_nxt   = b;
        phase_nxt = PH_V2LO;
      end
      PH_V1LO, PH_V2LO: begin
        has_cmd   = 1'b1;
        phase_nxt = PH_TOKEN;
        if (dist_bad) begin
          cmd.bad = 1'b1;
        end else begin
          cmd.kind = lzwd_pkg::CMD_COPY;
          cmd.len  = ncopy;
          bw_nxt   = bw_r + {9'd0, ncopy};
          wp_sum   = {1'b0, wptr_r} + (AW + 1)'(ncopy);
        end
      end
      default: begin
        phase_nxt = PH_VER;
      end
    endcase

    // Write pointer stays inside the history depth.
    wp_wrap  = wp_sum - DEPTH_W;
    wptr_nxt = (wp_sum >= DEPTH_W) ? wp_wrap[AW-1:0] : wp_sum[AW-1:0];

    // End of stream: the next word opens a new header.
    if ((phase_nxt == PH_RAW || phase_nxt == PH_TOKEN || phase_nxt == PH_LIT) &&
        bw_nxt >= {1'b0, target_nxt}) begin
      done      = 1'b1;
      has_cmd   = 1'b1;
      phase_nxt = PH_HDR0;
    end
    cmd.done = done;
  end

  assign q_push = accept && has_cmd;
  assign q_data = cmd;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      mode_r   <= lzwd_pkg::FMT_RAW;
      target_r <= '0;
      bw_r     <= '0;
      lit_r    <= '0;
      mlen_r   <= '0;
      dhi_r    <= '0;
      wptr_r   <= '0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      mode_r   <= mode_nxt;
      target_r <= target_nxt;
      bw_r     <= bw_nxt;
      lit_r    <= lit_nxt;
      mlen_r   <= mlen_nxt;
      dhi_r    <= dhi_nxt;
      wptr_r   <= wptr_nxt;
    end
  end

endmodule

// ----- hw/rtl/lzwd_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// lzwd_cmd_queue: two-entry command queue
// Decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
module lzwd_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lzwd_pkg::cmd_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output lzwd_pkg::cmd_t head
);

  lzwd_pkg::cmd_t slot_r [2];
  logic           rd_ptr_r;
  logic           wr_ptr_r;
  logic [1:0]     count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head       = slot_r[rd_ptr_r];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- hw/rtl/lzwd_back.sv -----
// ----------------------------------------------------------------------------
// lzwd_back: copy engine and result packer
// Writes history, copies matches byte by byte and packs words into results.
// ----------------------------------------------------------------------------
module lzwd_back #(
  parameter int unsigned HISTORY_DEPTH = 65536,
  parameter int unsigned OUT_LANES     = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  lzwd_pkg::cmd_t q_head,
  output logic           q_pop,
  lzwd_out_if.source     out_if
);

  localparam int unsigned AW    = $clog2(HISTORY_DEPTH);
  localparam int unsigned LANES = (OUT_LANES > 4) ? 4 : ((OUT_LANES < 1) ? 1 : OUT_LANES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(HISTORY_DEPTH - 1);
  localparam logic [2:0]    LANES_W   = 3'(LANES);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_READ  = 4'b0010,
    ST_WRITE = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_t;

  state_t         st_r, st_nxt;
  logic [7:0]     rem_r, rem_nxt;
  logic [AW-1:0]  rd_r, rd_nxt;
  logic [AW-1:0]  wr_r, wr_nxt;
  logic [31:0]    lanes_r, lanes_nxt;
  logic [2:0]     cnt_r, cnt_nxt;
  logic           done_r, done_nxt;
  logic           bad_r, bad_nxt;

  logic           out_valid_r;
  logic [31:0]    out_lanes_r;
  logic [2:0]     out_cnt_r;
  logic           out_last_r;
  logic           out_done_r;
  logic           out_bad_r;
  logic           out_free;
  logic           out_load;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [7:0]     ram_wdata;
  logic           ram_re;
  logic [7:0]     ram_rdata;

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_r),
    .rdata (ram_rdata)
  );

  assign out_free = !out_valid_r || out_if.ready;

  // Engine sequencing.
  always_comb begin
    st_nxt    = st_r;
    rem_nxt   = rem_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    lanes_nxt = lanes_r;
    cnt_nxt   = cnt_r;
    done_nxt  = done_r;
    bad_nxt   = bad_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;

    unique case (st_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          done_nxt  = q_head.done;
          bad_nxt   = q_head.bad;
          rd_nxt    = q_head.rd_addr[AW-1:0];
          wr_nxt    = q_head.wr_addr[AW-1:0];
          lanes_nxt = '0;
          cnt_nxt   = 3'd0;
          rem_nxt   = 8'd0;
          st_nxt    = ST_FLUSH;
          case (q_head.kind)
            lzwd_pkg::CMD_LIT: begin
              ram_we         = 1'b1;
              ram_waddr      = q_head.wr_addr[AW-1:0];
              ram_wdata      = q_head.data;
              lanes_nxt[7:0] = q_head.data;
              cnt_nxt        = 3'd1;
            end
            lzwd_pkg::CMD_COPY: begin
              rem_nxt = q_head.len;
              if (q_head.len != 8'd0) begin
                st_nxt = ST_READ;
              end
            end
            default: begin
              rem_nxt = 8'd0;
            end
          endcase
        end
      end
      ST_READ: begin
        ram_re = 1'b1;
        st_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        for (int j = 0; j < 4; j++) begin
          if (cnt_r == 3'(j)) begin
            lanes_nxt[j*8 +: 8] = ram_rdata;
          end
        end
        cnt_nxt = cnt_r + 3'd1;
        rem_nxt = rem_r - 8'd1;
        rd_nxt  = (rd_r == LAST_ADDR) ? '0 : rd_r + AW'(1);
        wr_nxt  = (wr_r == LAST_ADDR) ? '0 : wr_r + AW'(1);
        if (rem_r == 8'd1 || cnt_nxt == LANES_W) begin
          st_nxt = ST_FLUSH;
        end else begin
          st_nxt = ST_READ;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load  = 1'b1;
          lanes_nxt = '0;
          cnt_nxt   = 3'd0;
          st_nxt    = (rem_r == 8'd0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // Engine control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      rem_r  <= rem_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Engine payload registers.
  always_ff @(posedge clk) begin
    rd_r    <= rd_nxt;
    wr_r    <= wr_nxt;
    lanes_r <= lanes_nxt;
    done_r  <= done_nxt;
    bad_r   <= bad_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lanes_r <= lanes_r;
      out_cnt_r   <= cnt_r;
      out_last_r  <= (rem_r == 8'd0);
      out_done_r  <= done_r && (rem_r == 8'd0);
      out_bad_r   <= bad_r;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.out_byte0    = out_lanes_r[7:0];
  assign out_if.out_byte1    = out_lanes_r[15:8];
  assign out_if.out_byte2    = out_lanes_r[23:16];
  assign out_if.out_byte3    = out_lanes_r[31:24];
  assign out_if.byte_count   = out_cnt_r;
  assign out_if.run_last     = out_last_r;
  assign out_if.stream_done  = out_done_r;
  assign out_if.bad_distance = out_bad_r;

  // The packer never holds more words than there are lanes.
  a_lane_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LANES_W)
    else $error("lane count above lane limit");

  // A result without words must carry a flag.
  a_empty_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_cnt_r == 3'd0 |-> out_bad_r || out_done_r)
    else $error("empty result without flag");

  // A dropped match delivers no words.
  a_bad_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_cnt_r == 3'd0 && out_last_r)
    else $error("dropped match produced words");

endmodule

// ----- tb/sv/lz_window_decompressor_core_tb.sv -----
// ----------------------------------------------------------------------------
// lz_window_decompressor_core_tb: self-checking testbench of the decompressor
// Feeds headers, literal runs, matches and raw streams one word at a time,
// predicts every packed result in step with the stimulus and compares each
// result word, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lz_window_decompressor_core_tb;

  // Parser phases of the predictor.
  typedef enum logic [3:0] {
    S_HDR0  = 4'd0,
    S_VER   = 4'd1,
    S_SZLO  = 4'd2,
    S_SZHI  = 4'd3,
    S_RAW   = 4'd4,
    S_TOKEN = 4'd5,
    S_LIT   = 4'd6,
    S_V1LO  = 4'd7,
    S_V2HI  = 4'd8,
    S_V2LO  = 4'd9
  } phase_t;

  // One expected result word.
  typedef struct {
    logic [7:0] lane[4];
    logic [2:0] cnt;
    logic       last;
    logic       done;
    logic       bad;
  } out_word_t;

  logic clk;
  logic rst_n;
  bit   failed;
  int   tx_idle_pct;
  int   rx_idle_pct;

  lzwd_in_if  in_ch();
  lzwd_out_if out_ch();

  lz_window_decompressor_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // Decoder state of the predictor.
  phase_t      dec_phase;
  logic [1:0]  dec_fmt;
  logic [16:0] dec_target;
  logic [16:0] dec_written;
  logic [7:0]  dec_lits_left;
  logic [7:0]  dec_match_len;
  logic [7:0]  dec_dist_hi;
  logic [7:0]  dec_history[65536];
  logic [7:0]  emitted_bytes[$];
  out_word_t   expected_words[$];

  // Distance low byte chosen along with a match token.
  logic [7:0]  planned_dist_lo;

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Append one output byte unless the stream is already full.
  function automatic void emit_byte(logic [7:0] b);
    if (dec_written < dec_target) begin
      dec_history[dec_written[15:0]] = b;
      dec_written = dec_written + 1;
      emitted_bytes.push_back(b);
    end
  endfunction

  // Copy a match from history; returns 1 when the distance is out of range.
  function automatic bit copy_from_history(logic [15:0] dist_code);
    logic [16:0] match_dist;
    logic [16:0] pos;
    match_dist = {1'b0, dist_code} + 17'd1;
    if (match_dist > dec_written) return 1'b1;
    pos = dec_written - match_dist;
    for (int i = 0; i < dec_match_len && dec_written < dec_target; i++) begin
      emit_byte(dec_history[pos[15:0]]);
      pos = pos + 1;
    end
    return 1'b0;
  endfunction

  // Advance the decoder by one input word and queue the words it produces.
  function automatic void decode_word(logic [7:0] b);
    bit        bad;
    bit        done;
    int        nres;
    out_word_t w;
    bad = 1'b0;
    done = 1'b0;
    emitted_bytes.delete();
    case (dec_phase)
      S_VER: begin
        dec_fmt = (b == lzwd_pkg::VER1_BYTE) ? lzwd_pkg::FMT_V1 :
                  ((b == lzwd_pkg::VER2_BYTE) ? lzwd_pkg::FMT_V2 : lzwd_pkg::FMT_RAW);
        dec_phase = S_SZLO;
      end
      S_SZLO: begin
        dec_target = {9'd0, b};
        dec_phase = S_SZHI;
      end
      S_SZHI: begin
        dec_target[15:8] = b;
        dec_written = '0;
        dec_lits_left = '0;
        dec_match_len = '0;
        dec_dist_hi = '0;
        dec_phase = (dec_fmt == lzwd_pkg::FMT_RAW) ? S_RAW : S_TOKEN;
      end
      S_RAW: emit_byte(b);
      S_TOKEN: begin
        if (b[7]) begin
          if (dec_fmt == lzwd_pkg::FMT_V1) begin
            dec_match_len = {4'd0, b[6:3]} + 8'd3;
            dec_dist_hi = {5'd0, b[2:0]};
            dec_phase = S_V1LO;
          end else begin
            dec_match_len = {1'b0, b[6:0]} + 8'd4;
            dec_phase = S_V2HI;
          end
        end else begin
          dec_lits_left = {1'b0, b[6:0]} + 8'd1;
          dec_phase = S_LIT;
        end
      end
      S_LIT: begin
        emit_byte(b);
        dec_lits_left = dec_lits_left - 8'd1;
        if (dec_lits_left == 8'd0) dec_phase = S_TOKEN;
      end
      S_V1LO, S_V2LO: begin
        bad = copy_from_history({dec_dist_hi, b});
        dec_phase = S_TOKEN;
      end
      S_V2HI: begin
        dec_dist_hi = b;
        dec_phase = S_V2LO;
      end
      default: dec_phase = S_VER;
    endcase

    // A full stream sends the parser back to the header.
    if ((dec_phase == S_RAW || dec_phase == S_TOKEN || dec_phase == S_LIT) &&
        dec_written >= dec_target) begin
      done = 1'b1;
      dec_phase = S_HDR0;
    end

    nres = (emitted_bytes.size() + 3) / 4;
    if (nres == 0 && (bad || done)) nres = 1;
    for (int k = 0; k < nres; k++) begin
      w.cnt = '0;
      for (int j = 0; j < 4; j++) begin
        if (k * 4 + j < emitted_bytes.size()) begin
          w.lane[j] = emitted_bytes[k * 4 + j];
          w.cnt = w.cnt + 3'd1;
        end else begin
          w.lane[j] = '0;
        end
      end
      w.last = (k + 1 == nres);
      w.done = done && (k + 1 == nres);
      w.bad = bad;
      expected_words.push_back(w);
    end
  endfunction

  // Send one word, idling first at the current rate.
  task automatic send_word(logic [7:0] b);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    decode_word(b);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_list(logic [7:0] words[]);
    foreach (words[i]) send_word(words[i]);
  endtask

  // Pick a distance code, mostly one that reaches back into this stream.
  function automatic logic [15:0] pick_distance(int max_code);
    int reach;
    if (dec_written > 0 && $urandom_range(99) < 85) begin
      reach = (dec_written - 1 > max_code) ? max_code : dec_written - 1;
      if ($urandom_range(1)) reach = (reach > 8) ? 8 : reach;
      return $urandom_range(reach, 0);
    end
    return $urandom_range(max_code, 0);
  endfunction

  // Choose the next stream word so that most streams are well formed.
  function automatic logic [7:0] next_stream_word();
    logic [15:0] code;
    logic [7:0]  len;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 4) return $urandom_range(255, 0);
    case (dec_phase)
      S_VER: begin
        if (pick < 48) return lzwd_pkg::VER1_BYTE;
        if (pick < 90) return lzwd_pkg::VER2_BYTE;
        return $urandom_range(255, 0);
      end
      S_SZLO: return (pick < 90) ? $urandom_range(40, 0) : $urandom_range(255, 0);
      S_SZHI: return (pick < 97) ? 8'd0 : 8'd1;
      S_TOKEN: begin
        len = (pick < 85) ? $urandom_range(7, 0) : $urandom_range(127, 0);
        if ($urandom_range(1)) return {1'b0, len[6:0]};
        if (dec_fmt == lzwd_pkg::FMT_V1) begin
          code = pick_distance(2047);
          planned_dist_lo = code[7:0];
          return {1'b1, len[3:0], code[10:8]};
        end
        return {1'b1, len[6:0]};
      end
      S_V1LO: return planned_dist_lo;
      S_V2HI: begin
        code = pick_distance(65535);
        planned_dist_lo = code[7:0];
        return code[15:8];
      end
      S_V2LO: return planned_dist_lo;
      default: return $urandom_range(255, 0);
    endcase
  endfunction

  // Receiver stalls at the current rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    out_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected result word: byte_count %0d", out_ch.byte_count);
        failed = 1'b1;
      end else begin
        w = expected_words.pop_front();
        if (out_ch.out_byte0 !== w.lane[0]) begin
          $error("out_byte0: expected %0h, got %0h", w.lane[0], out_ch.out_byte0);
          failed = 1'b1;
        end
        if (out_ch.out_byte1 !== w.lane[1]) begin
          $error("out_byte1: expected %0h, got %0h", w.lane[1], out_ch.out_byte1);
          failed = 1'b1;
        end
        if (out_ch.out_byte2 !== w.lane[2]) begin
          $error("out_byte2: expected %0h, got %0h", w.lane[2], out_ch.out_byte2);
          failed = 1'b1;
        end
        if (out_ch.out_byte3 !== w.lane[3]) begin
          $error("out_byte3: expected %0h, got %0h", w.lane[3], out_ch.out_byte3);
          failed = 1'b1;
        end
        if (out_ch.byte_count !== w.cnt) begin
          $error("byte_count: expected %0d, got %0d", w.cnt, out_ch.byte_count);
          failed = 1'b1;
        end
        if (out_ch.run_last !== w.last) begin
          $error("run_last: expected %0b, got %0b", w.last, out_ch.run_last);
          failed = 1'b1;
        end
        if (out_ch.stream_done !== w.done) begin
          $error("stream_done: expected %0b, got %0b", w.done, out_ch.stream_done);
          failed = 1'b1;
        end
        if (out_ch.bad_distance !== w.bad) begin
          $error("bad_distance: expected %0b, got %0b", w.bad, out_ch.bad_distance);
          failed = 1'b1;
        end
      end
    end
  end

  // Empty stream, and a raw stream under an unknown version byte.
  task automatic test_raw_and_empty();
    send_list('{8'h00, lzwd_pkg::VER1_BYTE, 8'h00, 8'h00});
    send_list('{8'hFF, 8'h41, 8'h02, 8'h00, 8'h00, 8'hFF});
  endtask

  // Version 1: literals, a dropped match, and an overlapping match cut at the size.
  task automatic test_v1_stream();
    send_list('{8'h00, lzwd_pkg::VER1_BYTE, 8'h0A, 8'h00, 8'h01, 8'hAA, 8'h55,
                8'h80, 8'h05, 8'hF8, 8'h00});
  endtask

  // Version 2: longest matches past 256 bytes and a far distance that is dropped.
  task automatic test_v2_stream();
    send_list('{8'h00, lzwd_pkg::VER2_BYTE, 8'h20, 8'h01, 8'h00, 8'hC3, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00});
  endtask

  // Mostly well-formed streams with random content, under three idle patterns.
  task automatic test_random_streams();
    for (int n = 0; n < 430; n++) begin
      if (n == 143) begin
        tx_idle_pct = 58;
        rx_idle_pct = 27;
      end else if (n == 286) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_word(next_stream_word());
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    failed = 1'b0;
    tx_idle_pct = 27;
    rx_idle_pct = 58;
    dec_phase = S_HDR0;
    dec_fmt = lzwd_pkg::FMT_RAW;
    dec_target = '0;
    dec_written = '0;
    dec_lits_left = '0;
    dec_match_len = '0;
    dec_dist_hi = '0;
    planned_dist_lo = '0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = '0;
    out_ch.ready = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_raw_and_empty();
    test_v1_stream();
    test_v2_stream();
    test_random_streams();

    // Drain, then allow the longest match time to show any extra word.
    while (expected_words.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (!failed && expected_words.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #8000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
